>>> hw/rtl/rippc_pkg.sv
// Package for the read ID pair pattern classifier.
// Holds the item types, pattern codes and character constants.
// No dependencies.
`default_nettype none

package rippc_pkg;

    // Characters that the spaced pattern looks for
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Pattern codes; the check register uses CODE_NONE to accept any nonzero code
    typedef enum logic [1:0] {
        CODE_NONE   = 2'd0,
        CODE_SLASH  = 2'd1,
        CODE_SAME   = 2'd2,
        CODE_SPACED = 2'd3
    } t_code;

    // One character position of both identifiers
    typedef struct packed {
        logic [7:0] char_first;
        logic [7:0] char_second;
        logic       lengths_unequal;
        logic       last_pair;
    } t_in_item;

    // One classification result
    typedef struct packed {
        logic [1:0] pattern_code;
        logic       matches_res;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/rippc_if.sv
// Valid/ready channel interfaces for the classifier's input and result streams.
// Depends on rippc_pkg for the payload types.
`default_nettype none

interface rippc_in_if;
    import rippc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rippc_out_if;
    import rippc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rippc_in_stage.sv
// Input register stage: takes one character pair per cycle from the input channel while it is free.
// Depends on rippc_pkg and rippc_in_if.
`default_nettype none

module rippc_in_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    rippc_in_if.sink             i_in,
    input  wire                  i_take,
    output logic                 o_vld,
    output rippc_pkg::t_in_item  o_item
);
    import rippc_pkg::*;

    logic     r_vld;
    t_in_item r_item;

    // Stage is free when empty or when its item moves on this cycle
    assign i_in.ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    // Payload register, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

>>> hw/rtl/rippc_classify.sv
// Pattern scan flags, classification and result register.
// Depends on rippc_pkg and rippc_out_if.
`default_nettype none

module rippc_classify (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_vld,
    input  wire rippc_pkg::t_in_item i_item,
    input  wire [1:0]            i_check_code,
    output logic                 o_take,
    rippc_out_if.source          o_out
);
    import rippc_pkg::*;

    // Scan flags carried across positions of one identifier pair
    logic r_all_equal;
    logic r_scan_ok;
    logic r_space_pend;
    logic r_len_seen;

    logic      r_out_vld;
    t_out_item r_out;

    logic  out_free;
    logic  mismatch;
    logic  same;
    logic  one_two;
    logic  n_scan_ok;
    logic  n_space_pend;
    logic  p1;
    logic  p2;
    logic  p3;
    t_code code;
    logic  match;

    // A last pair needs a free result slot; other positions only touch the flags
    assign out_free = !r_out_vld || o_out.ready;
    assign o_take   = i_vld && (!i_item.last_pair || out_free);

    // Per-position compares
    assign mismatch = r_len_seen || i_item.lengths_unequal;
    assign same     = (i_item.char_first == i_item.char_second);
    assign one_two  = (i_item.char_first == CH_ONE) && (i_item.char_second == CH_TWO);

    // Space-one-two scan step
    always_comb begin
        n_scan_ok    = r_scan_ok;
        n_space_pend = 1'b0;
        if (r_scan_ok) begin
            if (r_space_pend) begin
                n_scan_ok = one_two;
            end else if (!same) begin
                n_scan_ok = 1'b0;
            end else if (i_item.char_first == CH_SPACE) begin
                if (i_item.last_pair) begin
                    n_scan_ok = 1'b0;
                end else begin
                    n_space_pend = 1'b1;
                end
            end
        end
    end

    // Classification on the last position, priority identical, slash, spaced
    assign p2 = !mismatch && r_all_equal && same;
    assign p1 = !mismatch && r_all_equal && one_two;
    assign p3 = !mismatch && n_scan_ok;

    always_comb begin
        if (p2) begin
            code = CODE_SAME;
        end else if (p1) begin
            code = CODE_SLASH;
        end else if (p3) begin
            code = CODE_SPACED;
        end else begin
            code = CODE_NONE;
        end
    end

    // Check register decode
    always_comb begin
        unique case (t_code'(i_check_code))
            CODE_SLASH:  match = p1;
            CODE_SAME:   match = p2;
            CODE_SPACED: match = p3;
            default:     match = (code != CODE_NONE);
        endcase
    end

    // Flag update; flags return to their start values after the last position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_equal  <= 1'b1;
            r_scan_ok    <= 1'b1;
            r_space_pend <= 1'b0;
            r_len_seen   <= 1'b0;
        end else if (o_take) begin
            if (i_item.last_pair) begin
                r_all_equal  <= 1'b1;
                r_scan_ok    <= 1'b1;
                r_space_pend <= 1'b0;
                r_len_seen   <= 1'b0;
            end else begin
                r_all_equal  <= r_all_equal && same;
                r_scan_ok    <= n_scan_ok;
                r_space_pend <= n_space_pend;
                r_len_seen   <= mismatch;
            end
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= o_take && i_item.last_pair;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last_pair) begin
            r_out.pattern_code <= code;
            r_out.matches_res  <= match;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/read_id_pair_pattern_classifier.sv
// Read ID pair pattern classifier: one character pair per cycle, one result per pair.
// A last pair passes from its input transfer through the input register to the result
// register. Throughput: one pair per cycle; a last pair waits in the input register
// only while the result register is full and not being taken.
// Reset (synchronous, active low): empties both stages, sets scan flags to their
// start values and the check register to accept any nonzero code.
`default_nettype none

module read_id_pair_pattern_classifier (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_wdata,
    rippc_in_if.sink   i_in,
    rippc_out_if.source o_out
);
    import rippc_pkg::*;

    logic [1:0] r_check;
    logic     s1_vld;
    t_in_item s1_item;
    logic     s1_take;

    // Check register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= CODE_NONE;
        end else if (i_cfg_we) begin
            r_check <= i_cfg_wdata;
        end
    end

    rippc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (s1_take),
        .o_vld   (s1_vld),
        .o_item  (s1_item)
    );

    rippc_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (s1_vld),
        .i_item       (s1_item),
        .i_check_code (r_check),
        .o_take       (s1_take),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire
